// ===== design/hcbd_pkg.sv =====
package hcbd_pkg;

    localparam int SIZE_BITS_DEFAULT = 32;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [1:0] {
        STATUS_BUSY = 2'd0,
        STATUS_OK   = 2'd1,
        STATUS_ERR  = 2'd2
    } status_t;

    typedef enum logic [8:0] {
        PH_SIZE    = 9'b000000001,
        PH_SIZE_LF = 9'b000000010,
        PH_DATA    = 9'b000000100,
        PH_DATA_CR = 9'b000001000,
        PH_DATA_LF = 9'b000010000,
        PH_END_CR  = 9'b000100000,
        PH_END_LF  = 9'b001000000,
        PH_DONE    = 9'b010000000,
        PH_ERROR   = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        status_t    body_status;
        logic       body_end;
    } result_t;

    // {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

endpackage

// ===== design/hcbd_step.sv =====
module hcbd_step #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output hcbd_pkg::result_t result
);
    import hcbd_pkg::*;

    phase_t               phase_reg, phase_next, phase_tmp;
    logic [SIZE_BITS-1:0] size_reg, size_next;
    logic [SIZE_BITS-1:0] remain_reg, remain_next;
    logic                 digit_seen_reg, digit_seen_next;
    logic [4:0]           hex;

    assign hex = hex_digit(in_byte);

    always_comb
    begin
        phase_tmp       = phase_reg;
        size_next       = size_reg;
        remain_next     = remain_reg;
        digit_seen_next = digit_seen_reg;
        result          = '0;

        unique case (phase_reg)
            PH_SIZE:
            begin
                if (hex[4])
                begin
                    // one more digit would overflow the size field
                    if (size_reg[SIZE_BITS-1 -: 4] != 4'd0)
                        phase_tmp = PH_ERROR;
                    else
                    begin
                        size_next       = {size_reg[SIZE_BITS-5:0], hex[3:0]};
                        digit_seen_next = 1'b1;
                    end
                end
                else if (in_byte == CH_CR && digit_seen_reg)
                    phase_tmp = PH_SIZE_LF;
                else
                    phase_tmp = PH_ERROR;
            end
            PH_SIZE_LF:
            begin
                if (in_byte != CH_LF)
                    phase_tmp = PH_ERROR;
                else if (size_reg == '0)
                    phase_tmp = PH_END_CR;
                else
                begin
                    remain_next = size_reg;
                    phase_tmp   = PH_DATA;
                end
            end
            PH_DATA:
            begin
                result.payload_valid = 1'b1;
                result.payload_byte  = in_byte;
                remain_next          = remain_reg - 1'b1;
                if (remain_reg == SIZE_BITS'(1))
                    phase_tmp = PH_DATA_CR;
            end
            PH_DATA_CR:
                phase_tmp = (in_byte == CH_CR) ? PH_DATA_LF : PH_ERROR;
            PH_DATA_LF:
            begin
                if (in_byte == CH_LF)
                begin
                    phase_tmp       = PH_SIZE;
                    size_next       = '0;
                    digit_seen_next = 1'b0;
                end
                else
                    phase_tmp = PH_ERROR;
            end
            PH_END_CR:
                phase_tmp = (in_byte == CH_CR) ? PH_END_LF : PH_ERROR;
            PH_END_LF:
                phase_tmp = (in_byte == CH_LF) ? PH_DONE : PH_ERROR;
            PH_DONE:
                phase_tmp = PH_DONE;
            PH_ERROR:
                phase_tmp = PH_ERROR;
            default:
                phase_tmp = PH_ERROR;
        endcase

        if (phase_tmp == PH_DONE)
            result.body_status = STATUS_OK;
        else if (phase_tmp == PH_ERROR || in_last)
            result.body_status = STATUS_ERR;
        else
            result.body_status = STATUS_BUSY;
        result.body_end = in_last;

        phase_next = phase_tmp;
        // last word of a body: back to the reset state
        if (in_last)
        begin
            phase_next      = PH_SIZE;
            size_next       = '0;
            remain_next     = '0;
            digit_seen_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            size_reg       <= '0;
            remain_reg     <= '0;
            digit_seen_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            size_reg       <= size_next;
            remain_reg     <= remain_next;
            digit_seen_reg <= digit_seen_next;
        end
    end

endmodule

// ===== design/http_chunked_body_decoder.sv =====
// Decodes an HTTP chunked body, one byte per word, at a sustained rate of one
// word per cycle while m_tready holds. Every input word gives exactly one output
// word, through the input register and then the result register; the chunk state
// advances as the word moves between them. tuser marks payload bytes, tdata carries the
// running body status, and tlast flags the result of the body's last byte,
// whose status is final: 1 complete, 2 malformed. Payload is forwarded as it
// arrives, so a consumer must drop it when the final status is 2.
module http_chunked_body_decoder #(
    parameter int SIZE_BITS = hcbd_pkg::SIZE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] payload_byte, [9:8] body_status, rest zero
    output logic        m_tuser,   // payload_valid
    output logic        m_tlast    // body_end
);
    import hcbd_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg;
    result_t    step_result;
    logic       advance;
    logic       fire;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    hcbd_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .in_byte (in_byte_reg),
        .in_last (in_last_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (fire)
            out_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.body_status, out_reg.payload_byte};
    assign m_tuser  = out_reg.payload_valid;
    assign m_tlast  = out_reg.body_end;

    // an empty result register never stalls the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
    else $error("input stalled with empty result register");

    // payload is never reported on a completed body
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (out_reg.body_status != STATUS_OK))
    else $error("payload byte after body completion");

    // the last byte always carries a final status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (out_reg.body_status != STATUS_BUSY))
    else $error("body end without final status");

    // non-payload results carry a zero byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (out_reg.payload_byte == 8'd0))
    else $error("nonzero byte on non-payload word");

endmodule

// ===== test/http_chunked_body_decoder_tb.sv =====
`timescale 1ns / 100ps

module http_chunked_body_decoder_tb;

    import hcbd_pkg::*;

    localparam int SZ          = SIZE_BITS_DEFAULT;
    localparam int RAND_WORDS  = 410;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN       = 8;

    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_LA   = "a";
    localparam logic [7:0] CH_LF_X = "f";
    localparam logic [7:0] CH_UA   = "A";
    localparam logic [7:0] CH_UF   = "F";

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_byte
    logic        s_tlast;   // in_last
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] payload_byte, [9:8] body_status, rest zero
    logic        m_tuser;   // payload_valid
    logic        m_tlast;   // body_end

    http_chunked_body_decoder u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // decoder shadow state
    phase_t        chunk_phase;
    logic [SZ-1:0] size_acc;
    logic [SZ-1:0] bytes_left;
    logic          have_digit;

    result_t     expected_words[$];
    logic [7:0]  body_bytes[$];

    int errors;
    int words_in;
    int words_out;
    int payload_words;
    int bodies_ok;
    int bodies_bad;
    int stall_cycles;
    bit idle_on;

    // directed words; pinned rows carry a hand-typed result
    typedef struct packed {
        logic [7:0] b;
        logic       l;
        logic       pin;
        logic       pv;
        status_t    st;
    } dir_row_t;

    dir_row_t dir_rows [32] = '{
        // well formed: payload extremes, trailing byte after completion
        '{"2",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_CR, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_LF, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{8'h00, 1'b0, 1'b1, 1'b1, STATUS_BUSY},
        '{8'hFF, 1'b0, 1'b1, 1'b1, STATUS_BUSY},
        '{CH_CR, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_LF, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"0",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_CR, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_LF, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_CR, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_LF, 1'b0, 1'b1, 1'b0, STATUS_OK},
        '{"x",   1'b1, 1'b1, 1'b0, STATUS_OK},
        // non-hex size digit
        '{"G",   1'b1, 1'b1, 1'b0, STATUS_ERR},
        // empty size line
        '{CH_CR, 1'b1, 1'b1, 1'b0, STATUS_ERR},
        // CR without LF
        '{"1",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_CR, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"X",   1'b1, 1'b1, 1'b0, STATUS_ERR},
        // leading zero, body cut inside payload
        '{"0",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"1",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_CR, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{CH_LF, 1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"p",   1'b1, 1'b1, 1'b1, STATUS_ERR},
        // size overflows 32 bits on the ninth digit
        '{"F",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"F",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"F",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"F",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"f",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"f",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"f",   1'b0, 1'b0, 1'b0, STATUS_BUSY},
        '{"f",   1'b0, 1'b1, 1'b0, STATUS_BUSY},
        '{"0",   1'b1, 1'b1, 1'b0, STATUS_ERR}
    };

    function automatic void clear_decoder();
        chunk_phase = PH_SIZE;
        size_acc    = '0;
        bytes_left  = '0;
        have_digit  = 1'b0;
    endfunction

    function automatic result_t decode_byte(input logic [7:0] b, input logic l);
        result_t    r;
        logic       is_hex;
        logic [3:0] nib;
        r      = '0;
        is_hex = 1'b1;
        nib    = '0;
        if (b >= CH_ZERO && b <= CH_NINE)
            nib = 4'(b - CH_ZERO);
        else if (b >= CH_LA && b <= CH_LF_X)
            nib = 4'(b - CH_LA + 8'd10);
        else if (b >= CH_UA && b <= CH_UF)
            nib = 4'(b - CH_UA + 8'd10);
        else
            is_hex = 1'b0;

        case (chunk_phase)
            PH_SIZE:
            begin
                if (is_hex)
                begin
                    if (size_acc[SZ-1 -: 4] != 0)
                        chunk_phase = PH_ERROR;
                    else
                    begin
                        size_acc   = {size_acc[SZ-5:0], nib};
                        have_digit = 1'b1;
                    end
                end
                else if (b == CH_CR && have_digit)
                    chunk_phase = PH_SIZE_LF;
                else
                    chunk_phase = PH_ERROR;
            end
            PH_SIZE_LF:
            begin
                if (b != CH_LF)
                    chunk_phase = PH_ERROR;
                else if (size_acc == 0)
                    chunk_phase = PH_END_CR;
                else
                begin
                    bytes_left  = size_acc;
                    chunk_phase = PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
                bytes_left      = bytes_left - 1'b1;
                if (bytes_left == 0)
                    chunk_phase = PH_DATA_CR;
            end
            PH_DATA_CR:
                chunk_phase = (b == CH_CR) ? PH_DATA_LF : PH_ERROR;
            PH_DATA_LF:
            begin
                if (b == CH_LF)
                begin
                    chunk_phase = PH_SIZE;
                    size_acc    = '0;
                    have_digit  = 1'b0;
                end
                else
                    chunk_phase = PH_ERROR;
            end
            PH_END_CR:
                chunk_phase = (b == CH_CR) ? PH_END_LF : PH_ERROR;
            PH_END_LF:
                chunk_phase = (b == CH_LF) ? PH_DONE : PH_ERROR;
            PH_DONE:
                ;
            default:
                chunk_phase = PH_ERROR;
        endcase

        if (chunk_phase == PH_DONE)
            r.body_status = STATUS_OK;
        else if (chunk_phase == PH_ERROR)
            r.body_status = STATUS_ERR;
        else
            r.body_status = l ? STATUS_ERR : STATUS_BUSY;
        r.body_end = l;

        if (l)
            clear_decoder();
        return r;
    endfunction

    // drive one word, wait for the handshake, then log what must come back
    task automatic push_word(input logic [7:0] b, input logic l, input logic pin,
                             input result_t pinned);
        result_t r;
        while (idle_on && $urandom_range(99) < 27)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = decode_byte(b, l);
        if (pin)
            r = pinned;
        expected_words.insert(expected_words.size(), r);
        words_in++;
        if (r.payload_valid)
            payload_words++;
        if (l && r.body_status == STATUS_OK)
            bodies_ok++;
        if (l && r.body_status == STATUS_ERR)
            bodies_bad++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        body_bytes.insert(body_bytes.size(), b);
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(1) ? CH_LA : CH_UA) + 8'(d) - 8'd10;
    endfunction

    task automatic put_size(input logic [39:0] v);
        int nd;
        nd = 1;
        while (nd < 10 && (v >> (4 * nd)) != 0)
            nd++;
        repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0)
            add_byte(CH_ZERO);
        for (int i = nd - 1; i >= 0; i--)
            add_byte(hex_char(v[4*i +: 4]));
    endtask

    task automatic put_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endtask

    // mostly well formed bodies with random content, some broken, some noise
    task automatic make_body();
        int kind;
        int n;
        int pos;
        body_bytes.delete();
        kind = $urandom_range(99);
        if (kind < 72)
        begin
            repeat ($urandom_range(0, 3))
            begin
                n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                put_size(40'(n));
                put_crlf();
                repeat (n)
                    add_byte(8'($urandom()));
            end
            put_size(40'd0);
            put_crlf();
            put_crlf();
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(1, 3))
                    add_byte(8'($urandom()));
            if ($urandom_range(99) < 30)
            begin
                pos = $urandom_range(body_bytes.size() - 1);
                case ($urandom_range(2))
                    0: body_bytes[pos] = 8'($urandom());
                    1: while (body_bytes.size() > pos + 1) void'(body_bytes.pop_back());
                    default: body_bytes.insert(pos, 8'($urandom()));
                endcase
            end
        end
        else if (kind < 86)
        begin
            put_size({8'($urandom_range(1, 255)), 32'($urandom())});
            put_crlf();
            add_byte(8'($urandom()));
        end
        else
            repeat ($urandom_range(1, 6))
                add_byte(8'($urandom()));
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on output word %0d, %s: got %0h, expected %0h",
                 words_out, field, got, want);
        errors++;
    endtask

    // result side: random backpressure and in-order compare
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin : sink
            result_t e;
            m_tready <= !(idle_on && $urandom_range(99) < 27);
            if (m_tvalid && m_tready)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("word with none expected", m_tdata, 16'h0);
                else
                begin
                    e = expected_words.pop_front();
                    if (m_tdata[7:0] !== e.payload_byte)
                        report_mismatch("payload_byte", 16'(m_tdata[7:0]),
                                        16'(e.payload_byte));
                    if (m_tuser !== e.payload_valid)
                        report_mismatch("payload_valid", 16'(m_tuser),
                                        16'(e.payload_valid));
                    if (m_tdata[9:8] !== e.body_status)
                        report_mismatch("body_status", 16'(m_tdata[9:8]),
                                        16'(e.body_status));
                    if (m_tlast !== e.body_end)
                        report_mismatch("body_end", 16'(m_tlast), 16'(e.body_end));
                    if (m_tdata[15:10] !== 6'd0)
                        report_mismatch("tdata pad", 16'(m_tdata[15:10]), 16'h0);
                end
                words_out++;
            end
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAIL http_chunked_body_decoder");
                $finish;
            end
        end
    end

    initial
    begin
        int rand_words;
        result_t pinned;
        errors        = 0;
        words_in      = 0;
        words_out     = 0;
        payload_words = 0;
        bodies_ok     = 0;
        bodies_bad    = 0;
        stall_cycles  = 0;
        idle_on       = 1'b1;
        rand_words    = 0;
        clear_decoder();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            pinned.payload_byte  = dir_rows[i].pv ? dir_rows[i].b : 8'h00;
            pinned.payload_valid = dir_rows[i].pv;
            pinned.body_status   = dir_rows[i].st;
            pinned.body_end      = dir_rows[i].l;
            push_word(dir_rows[i].b, dir_rows[i].l, dir_rows[i].pin, pinned);
        end

        while (rand_words < RAND_WORDS)
        begin
            // a stretch at full rate on both sides
            idle_on = !(rand_words >= 150 && rand_words < 260);
            make_body();
            foreach (body_bytes[i])
                push_word(body_bytes[i], i == body_bytes.size() - 1, 1'b0, '0);
            rand_words += body_bytes.size();
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("%0d words in, %0d out, %0d payload bytes", words_in, words_out,
                 payload_words);
        $display("%0d bodies completed, %0d ended malformed", bodies_ok, bodies_bad);
        if (errors == 0)
            $display("PASS http_chunked_body_decoder");
        else
            $display("FAIL http_chunked_body_decoder");
        $finish;
    end

endmodule
